### sv/tpq_pkg.sv
// Package for the two-class priority task queue: item types, codes and defaults.
package tpq_pkg;

  localparam int ListDepthDefault = 16;
  localparam logic [7:0] GfxLevelReset = 8'd0;

  localparam logic [1:0] CmdAdd  = 2'd0;
  localparam logic [1:0] CmdNext = 2'd1;
  localparam logic [1:0] CmdGfx  = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_tag;
    logic [7:0]  priority_req;
    logic        concurrent_class;
    logic        main_first;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] out_tag;
    logic [7:0]  out_priority;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
  } entry_t;

  localparam int EntryWidth = $bits(entry_t);

endpackage

### sv/two_class_priority_task_queue.sv
// Two-class priority task queue: list storage, scan/shift sequencer and item ports.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_item_i  (tpq_pkg::in_item_t)
//   out       output     out_valid_o/out_ready_i out_item_o (tpq_pkg::out_item_t)
//   cfg       input      cfg_we_i                cfg_wdata_i (graphics level)
//
// Add, full, empty and unused commands go from idle straight to the done state.
// Take commands scan the selected list through one RAM read port and one compare,
// then shift the tail down one entry a cycle. in_ready_o is high only when idle.
// Reset clears both list counts; list storage needs no clearing.
// A result waits in the output register while the next item is accepted.
module two_class_priority_task_queue #(
  parameter int LIST_DEPTH = tpq_pkg::ListDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tpq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tpq_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam int RamDepth = 2 ** AW;
  localparam logic [CW-1:0] CntFull = CW'(LIST_DEPTH);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StShift = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] main_cnt_q, main_cnt_d;
  logic [CW-1:0] conc_cnt_q, conc_cnt_d;
  logic [7:0]    gl_q, gl_d;
  logic          out_valid_q, out_valid_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d;
  logic          sel_q, sel_d;
  logic          gfx_q, gfx_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  tpq_pkg::entry_t    best_q, best_d;
  tpq_pkg::out_item_t res_q, res_d;
  tpq_pkg::out_item_t out_q, out_d;

  logic                          sel_new;
  logic [CW-1:0]                 n_new;
  logic [CW-1:0]                 n_cur;
  logic                          rd_more;
  logic                          take;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [tpq_pkg::EntryWidth-1:0] ram_wdata;
  logic [tpq_pkg::EntryWidth-1:0] ram_rdata;
  tpq_pkg::entry_t               rd_entry;

  tpq_ram #(
    .WIDTH (tpq_pkg::EntryWidth),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = tpq_pkg::entry_t'(ram_rdata);
  assign n_cur    = sel_q ? conc_cnt_q : main_cnt_q;
  assign rd_more  = ptr_q < n_cur;
  assign n_new    = sel_new ? conc_cnt_q : main_cnt_q;

  always_comb begin
    unique case (in_item_i.command)
      tpq_pkg::CmdAdd:  sel_new = in_item_i.concurrent_class;
      tpq_pkg::CmdNext: sel_new = !(in_item_i.main_first && (main_cnt_q != '0));
      tpq_pkg::CmdGfx:  sel_new = in_item_i.concurrent_class || (main_cnt_q == '0);
      default:          sel_new = 1'b0;
    endcase
  end

  always_comb begin
    take = 1'b0;
    if (gfx_q) begin
      take = (pidx_q == '0) || (!found_q && (rd_entry.prio == gl_q));
    end else begin
      take = (pidx_q == '0) || (rd_entry.prio > best_q.prio);
    end
  end

  always_comb begin
    state_d     = state_q;
    main_cnt_d  = main_cnt_q;
    conc_cnt_d  = conc_cnt_q;
    gl_d        = cfg_we_i ? cfg_wdata_i : gl_q;
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    found_d     = found_q;
    sel_d       = sel_q;
    gfx_d       = gfx_q;
    ptr_d       = ptr_q;
    pidx_d      = pidx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = {sel_q, pidx_q - IW'(1)};
    ram_wdata   = ram_rdata;
    ram_raddr   = {sel_q, ptr_q[IW-1:0]};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          sel_d   = sel_new;
          gfx_d   = (in_item_i.command == tpq_pkg::CmdGfx);
          ptr_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          res_d   = '0;
          state_d = StDone;
          unique case (in_item_i.command) inside
            tpq_pkg::CmdAdd: begin
              if (n_new >= CntFull) begin
                res_d.status = tpq_pkg::StatusFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = {sel_new, n_new[IW-1:0]};
                ram_wdata = {in_item_i.task_tag, in_item_i.priority_req};
                if (sel_new) begin
                  conc_cnt_d = conc_cnt_q + CW'(1);
                end else begin
                  main_cnt_d = main_cnt_q + CW'(1);
                end
                res_d.status = tpq_pkg::StatusOk;
              end
            end
            tpq_pkg::CmdNext, tpq_pkg::CmdGfx: begin
              if (n_new == '0) begin
                res_d.status = tpq_pkg::StatusEmpty;
              end else begin
                state_d = StScan;
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      StScan: begin
        if (rd_more) begin
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = ptr_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (take) begin
            best_idx_d = pidx_q;
            best_d     = rd_entry;
            if (gfx_q && (pidx_q != '0)) begin
              found_d = 1'b1;
            end
          end
          if (!rd_more) begin
            state_d = StShift;
            ptr_d   = CW'(best_idx_d) + CW'(1);
            pend_d  = 1'b0;
          end
        end
      end
      StShift: begin
        // move each later entry down by one to close the gap
        ram_we = pend_q;
        if (rd_more) begin
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = ptr_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
          if (sel_q) begin
            conc_cnt_d = conc_cnt_q - CW'(1);
          end else begin
            main_cnt_d = main_cnt_q - CW'(1);
          end
          res_d.granted      = 1'b1;
          res_d.out_tag      = best_q.tag;
          res_d.out_priority = best_q.prio;
          res_d.status       = tpq_pkg::StatusOk;
          state_d            = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      main_cnt_q  <= '0;
      conc_cnt_q  <= '0;
      gl_q        <= tpq_pkg::GfxLevelReset;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      main_cnt_q  <= main_cnt_d;
      conc_cnt_q  <= conc_cnt_d;
      gl_q        <= gl_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    gfx_q      <= gfx_d;
    ptr_q      <= ptr_d;
    pidx_q     <= pidx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/tpq_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module tpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
